[rtl/lir_pkg.sv]
`default_nettype none
package lir_pkg;

  // Frame and phase formats
  localparam int MAX_CHANNELS    = 8;
  localparam int SAMPLE_BITS     = 24;
  localparam int PHASE_FRAC_BITS = 28;
  localparam int PHASE_BITS      = PHASE_FRAC_BITS + 5;
  localparam int STEP_BITS       = 32;
  localparam int CH_BITS         = 4;
  localparam int MAX_RESULTS     = 8;
  localparam int RES_BITS        = $clog2(MAX_RESULTS);

  localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << PHASE_FRAC_BITS;

  // Register reset values
  localparam logic [STEP_BITS-1:0] STEP_RESET   = STEP_BITS'(PHASE_ONE);
  localparam logic [CH_BITS-1:0]   CH_DEFAULT   = CH_BITS'(2);
  localparam logic [CH_BITS-1:0]   CH_MAX       = CH_BITS'(MAX_CHANNELS);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_PHASE_STEP    = 2'd0,
    REG_CHANNEL_COUNT = 2'd1,
    REG_BYPASS        = 2'd2
  } lir_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Load request from the sequencer to the output stage
  typedef struct packed {
    logic load;
    logic bypass;
    logic run_end;
  } lir_push_t;

endpackage
`default_nettype wire

[rtl/lir_lane.sv]
`default_nettype none
module lir_lane import lir_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire sample_t                    cur,
  input  wire sample_t                    prev,
  input  wire logic [PHASE_FRAC_BITS-1:0] frac,
  output sample_t                         interp
);

  logic signed [SAMPLE_BITS:0]                 diff;
  logic signed [PHASE_FRAC_BITS:0]             phase_op;
  logic signed [SAMPLE_BITS+PHASE_FRAC_BITS+1:0] prod;
  logic [SAMPLE_BITS-1:0]                      term;

  // Scale the frame-to-frame difference by the phase fraction
  assign diff     = {cur[SAMPLE_BITS-1], cur} - {prev[SAMPLE_BITS-1], prev};
  assign phase_op = {1'b0, frac};
  assign prod     = diff * phase_op;

  // Hold the floored product; only the low sample bits matter after wrap
  always_ff @(posedge clk) begin
    if (en) begin
      term <= prod[SAMPLE_BITS+PHASE_FRAC_BITS-1:PHASE_FRAC_BITS];
    end
  end

  assign interp = sample_t'(prev + term);

endmodule
`default_nettype wire

[rtl/lir_merge.sv]
`default_nettype none
module lir_merge import lir_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lir_push_t          push,
  input  wire sample_t            lane_val [MAX_CHANNELS],
  input  wire sample_t            byp_val  [MAX_CHANNELS],
  input  wire logic [CH_BITS-1:0] nch,
  output logic                    free,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output sample_t                 out_val  [MAX_CHANNELS],
  output logic                    run_end
);

  assign free = !out_valid || out_ready;

  // Output word valid: set on load, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Gather lane results, zero the inactive channels
  always_ff @(posedge clk) begin
    if (push.load) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        if (CH_BITS'(c) < nch) begin
          out_val[c] <= push.bypass ? byp_val[c] : lane_val[c];
        end else begin
          out_val[c] <= '0;
        end
      end
      run_end <= push.run_end;
    end
  end

endmodule
`default_nettype wire

[rtl/linear_interp_resampler.sv]
`default_nettype none
// Multichannel linear-interpolation resampler.
// Input channel (in_valid/in_ready) carries one frame of eight signed
// samples; channels past the effective count are stored, output as zero.
// Output channel (out_valid/out_ready) carries interpolated frames; run_end
// marks the last word caused by an input frame. A frame may cause no word.
// Config channel (cfg_valid/cfg_ready, always ready) writes phase_step,
// channel_count and bypass by index; write only while the block is idle.
// A frame yields up to eight output words. Each word passes the lane
// multipliers in S_MUL and loads the output register in S_PUSH; a frame
// with no word passes S_MUL alone, and a bypass frame goes through S_BYP
// straight to the output register. A new frame is taken once the previous
// frame's last word is in the output register, even while that word still
// waits.
// A stalled receiver holds the output word; the sequencer then waits.
// Reset (synchronous) clears the previous frame and phase and restores the
// registers to step 1.0, two channels, bypass on.
module linear_interp_resampler import lir_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [STEP_BITS-1:0] cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire sample_t              in_ch0,
  input  wire sample_t              in_ch1,
  input  wire sample_t              in_ch2,
  input  wire sample_t              in_ch3,
  input  wire sample_t              in_ch4,
  input  wire sample_t              in_ch5,
  input  wire sample_t              in_ch6,
  input  wire sample_t              in_ch7,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sample_t                   out_ch0,
  output sample_t                   out_ch1,
  output sample_t                   out_ch2,
  output sample_t                   out_ch3,
  output sample_t                   out_ch4,
  output sample_t                   out_ch5,
  output sample_t                   out_ch6,
  output sample_t                   out_ch7,
  output logic                      run_end
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_PUSH = 4'b0100,
    S_BYP  = 4'b1000
  } state_t;

  state_t                  state, state_next;
  logic [STEP_BITS-1:0]    phase_step;
  logic [CH_BITS-1:0]      channel_count;
  logic                    bypass;
  logic [PHASE_BITS-1:0]   phase_acc;
  logic [PHASE_BITS-1:0]   phase_sum;
  logic [PHASE_BITS-1:0]   phase_wrap;
  logic [RES_BITS-1:0]     res_idx;
  logic                    last;
  logic                    last_next;
  logic                    below_one;
  logic                    lane_en;
  logic                    finish;
  logic                    free;
  logic [CH_BITS-1:0]      nch;
  lir_push_t               push;
  sample_t                 cur      [MAX_CHANNELS];
  sample_t                 prev     [MAX_CHANNELS];
  sample_t                 lane_val [MAX_CHANNELS];
  sample_t                 out_val  [MAX_CHANNELS];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // Effective channel count
  always_comb begin
    if (channel_count == '0) begin
      nch = CH_DEFAULT;
    end else if (channel_count > CH_MAX) begin
      nch = CH_MAX;
    end else begin
      nch = channel_count;
    end
  end

  // Phase arithmetic
  assign below_one  = (phase_acc[PHASE_BITS-1:PHASE_FRAC_BITS] == '0);
  assign phase_sum  = phase_acc + PHASE_BITS'(phase_step);
  assign last_next  = (phase_sum[PHASE_BITS-1:PHASE_FRAC_BITS] != '0) ||
                      (res_idx == RES_BITS'(MAX_RESULTS - 1));
  assign phase_wrap = below_one ? '0 : phase_acc - PHASE_ONE;

  // Sequencer
  always_comb begin
    state_next = state;
    push       = '0;
    lane_en    = 1'b0;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = bypass ? S_BYP : S_MUL;
        end
      end
      S_MUL: begin
        if (below_one) begin
          lane_en    = 1'b1;
          state_next = S_PUSH;
        end else begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PUSH: begin
        if (free) begin
          push.load    = 1'b1;
          push.run_end = last;
          if (last) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_BYP: begin
        if (free) begin
          push.load    = 1'b1;
          push.bypass  = 1'b1;
          push.run_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers, configuration and stored frame
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase_step    <= STEP_RESET;
      channel_count <= CH_DEFAULT;
      bypass        <= 1'b1;
      phase_acc     <= '0;
      res_idx       <= '0;
      last          <= 1'b0;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        prev[c] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == REG_PHASE_STEP) begin
          phase_step <= cfg_data;
        end else if (cfg_index == REG_CHANNEL_COUNT) begin
          channel_count <= cfg_data[CH_BITS-1:0];
        end else if (cfg_index == REG_BYPASS) begin
          bypass <= cfg_data[0];
        end
      end
      // Advance the phase for each word computed
      if (lane_en) begin
        phase_acc <= phase_sum;
        last      <= last_next;
      end
      // Drop one frame period off the phase at frame end, saturating at zero
      if (finish) begin
        phase_acc <= phase_wrap;
        res_idx   <= '0;
      end else if (push.load && !push.bypass) begin
        res_idx <= res_idx + RES_BITS'(1);
      end
      if (finish || push.bypass) begin
        prev <= cur;
      end
    end
  end

  // Capture the arriving frame
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur[0] <= in_ch0;
      cur[1] <= in_ch1;
      cur[2] <= in_ch2;
      cur[3] <= in_ch3;
      cur[4] <= in_ch4;
      cur[5] <= in_ch5;
      cur[6] <= in_ch6;
      cur[7] <= in_ch7;
    end
  end

  // One interpolation lane per channel
  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    lir_lane u_lane (
      .clk    (clk),
      .en     (lane_en),
      .cur    (cur[g]),
      .prev   (prev[g]),
      .frac   (phase_acc[PHASE_FRAC_BITS-1:0]),
      .interp (lane_val[g])
    );
  end

  lir_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .lane_val  (lane_val),
    .byp_val   (cur),
    .nch       (nch),
    .free      (free),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_val   (out_val),
    .run_end   (run_end)
  );

  assign out_ch0 = out_val[0];
  assign out_ch1 = out_val[1];
  assign out_ch2 = out_val[2];
  assign out_ch3 = out_val[3];
  assign out_ch4 = out_val[4];
  assign out_ch5 = out_val[5];
  assign out_ch6 = out_val[6];
  assign out_ch7 = out_val[7];

  // Never overwrite a word the receiver has not taken
  assert property (@(posedge clk) disable iff (rst)
    push.load |-> (!out_valid || out_ready))
    else $error("output word overwritten");

  // Word count starts from zero for every frame
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (res_idx == '0))
    else $error("word count not cleared between frames");

  // An interpolated frame goes straight to the lanes
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !bypass) |=> (state == S_MUL))
    else $error("frame not started after accept");

  // A phase below one in S_MUL always yields a word
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && below_one) |=> (state == S_PUSH))
    else $error("lane result lost");

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top import lir_pkg::*; ;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_SETTINGS = 12;
  localparam int FRAMES_PER_SETTING = 33;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef logic [MAX_CHANNELS-1:0][SAMPLE_BITS-1:0] frame_t;
  typedef struct packed {
    frame_t samples;
    logic   last;
  } out_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [STEP_BITS-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  frame_t               drv_frame = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sample_t              out_ch0, out_ch1, out_ch2, out_ch3;
  sample_t              out_ch4, out_ch5, out_ch6, out_ch7;
  logic                 run_end;
  frame_t               got_frame;

  assign got_frame = {out_ch7, out_ch6, out_ch5, out_ch4, out_ch3, out_ch2, out_ch1, out_ch0};

  linear_interp_resampler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ch0    (drv_frame[0]),
    .in_ch1    (drv_frame[1]),
    .in_ch2    (drv_frame[2]),
    .in_ch3    (drv_frame[3]),
    .in_ch4    (drv_frame[4]),
    .in_ch5    (drv_frame[5]),
    .in_ch6    (drv_frame[6]),
    .in_ch7    (drv_frame[7]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ch0   (out_ch0),
    .out_ch1   (out_ch1),
    .out_ch2   (out_ch2),
    .out_ch3   (out_ch3),
    .out_ch4   (out_ch4),
    .out_ch5   (out_ch5),
    .out_ch6   (out_ch6),
    .out_ch7   (out_ch7),
    .run_end   (run_end)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Resampler state and register copies
  frame_t                 prev_samples;
  logic [PHASE_BITS-1:0]  phase_pos;
  logic [STEP_BITS-1:0]   step_reg;
  logic [CH_BITS-1:0]     chan_reg;
  logic                   bypass_reg;

  frame_t    pending_frames[$];
  out_word_t expected_words[$];

  int errors = 0;
  int frames_in = 0;
  int words_seen = 0;
  int settings_run = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int pattern_count = 0;

  task automatic report_error(string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    errors++;
  endtask

  function automatic int unsigned active_lanes();
    if (chan_reg == 0) return 2;
    if (chan_reg > MAX_CHANNELS) return MAX_CHANNELS;
    return int'(chan_reg);
  endfunction

  // Interpolate between the stored frame and the new one, queue the words
  task automatic predict_frame(frame_t cur);
    out_word_t   run[MAX_RESULTS];
    out_word_t   w;
    int unsigned lanes;
    int          n;
    longint      diff;
    longint      prod;
    longint      v;
    lanes = active_lanes();
    if (bypass_reg) begin
      w.samples = '0;
      for (int c = 0; c < MAX_CHANNELS; c++)
        if (c < lanes) w.samples[c] = cur[c];
      w.last = 1'b1;
      expected_words.push_back(w);
    end else begin
      n = 0;
      while (phase_pos < PHASE_ONE && n < MAX_RESULTS) begin
        w.samples = '0;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          if (c < lanes) begin
            diff = longint'($signed(cur[c])) - longint'($signed(prev_samples[c]));
            prod = diff * longint'(phase_pos);
            // arithmetic shift floors the product
            v = longint'($signed(prev_samples[c])) + (prod >>> PHASE_FRAC_BITS);
            w.samples[c] = v[SAMPLE_BITS-1:0];
          end
        end
        w.last = 1'b0;
        run[n] = w;
        n++;
        phase_pos = phase_pos + PHASE_BITS'(step_reg);
      end
      if (n > 0) run[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_words.push_back(run[i]);
      // drop one input period, saturating at zero
      if (phase_pos >= PHASE_ONE) phase_pos = phase_pos - PHASE_ONE;
      else phase_pos = '0;
    end
    prev_samples = cur;
  endtask

  // Input driver: bursts with random gaps
  always @(posedge clk) begin : driver
    frame_t f;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_frame(drv_frame);
        frames_in++;
      end
      if (in_valid && !in_ready) begin
        // hold the word until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_frames.size() > 0) begin
        f = pending_frames.pop_front();
        drv_frame <= f;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor and receiver stall pattern
  always @(posedge clk) begin : monitor
    out_word_t w;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_error($sformatf("word %0d arrived with nothing expected", words_seen));
        end else begin
          w = expected_words.pop_front();
          for (int c = 0; c < MAX_CHANNELS; c++)
            if (got_frame[c] !== w.samples[c])
              report_error($sformatf("word %0d out_ch%0d got %0d expected %0d", words_seen,
                                     c, $signed(got_frame[c]), $signed(w.samples[c])));
          if (run_end !== w.last)
            report_error($sformatf("word %0d run_end got %b expected %b", words_seen,
                                   run_end, w.last));
        end
        words_seen++;
      end
      // switch stall style now and then
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      pattern_count++;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (pattern_count % 5) > 1;
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout with %0d words still expected", expected_words.size());
      $display("FAIL linear_interp_resampler");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [STEP_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_PHASE_STEP:    step_reg = data;
      REG_CHANNEL_COUNT: chan_reg = data[CH_BITS-1:0];
      REG_BYPASS:        bypass_reg = data[0];
      default:           ;
    endcase
  endtask

  // Wait until all frames are taken and every word has come out
  task automatic wait_idle();
    @(posedge clk);
    while (pending_frames.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic frame_t fill_frame(logic [SAMPLE_BITS-1:0] s);
    frame_t f;
    for (int c = 0; c < MAX_CHANNELS; c++) f[c] = s;
    return f;
  endfunction

  function automatic frame_t mixed_frame(bit flip);
    frame_t f;
    for (int c = 0; c < MAX_CHANNELS; c++)
      f[c] = ((c % 2 == 0) ^ flip) ? SAMPLE_MAX : SAMPLE_MIN;
    return f;
  endfunction

  function automatic frame_t random_frame(frame_t last);
    frame_t f;
    int     mode;
    mode = $urandom_range(0, 19);
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (mode < 14) begin
        f[c] = $urandom();
      end else if (mode < 17) begin
        // small move from the last frame
        f[c] = last[c] + SAMPLE_BITS'($urandom_range(0, 1024)) - SAMPLE_BITS'(512);
      end else begin
        case ($urandom_range(0, 2))
          0:       f[c] = SAMPLE_MAX;
          1:       f[c] = SAMPLE_MIN;
          default: f[c] = '0;
        endcase
      end
    end
    return f;
  endfunction

  initial begin : stimulus
    frame_t               last;
    int                   first;
    logic [STEP_BITS-1:0] step;
    logic [STEP_BITS-1:0] chans;
    prev_samples = '0;
    phase_pos = '0;
    step_reg = STEP_RESET;
    chan_reg = CH_DEFAULT;
    bypass_reg = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // bypass with reset settings, upper channels zeroed
    pending_frames.push_back(fill_frame(SAMPLE_MAX));
    pending_frames.push_back(fill_frame(SAMPLE_MIN));
    wait_idle();
    settings_run++;

    // fractional step across full-scale swings on all channels
    write_reg(REG_BYPASS, '0);
    write_reg(REG_CHANNEL_COUNT, 32'd8);
    write_reg(REG_PHASE_STEP, 32'h0C00_0000);
    pending_frames.push_back(fill_frame(SAMPLE_MIN));
    pending_frames.push_back(fill_frame(SAMPLE_MAX));
    pending_frames.push_back(fill_frame(SAMPLE_MAX));
    pending_frames.push_back(mixed_frame(1'b0));
    pending_frames.push_back(mixed_frame(1'b1));
    pending_frames.push_back(fill_frame('0));
    wait_idle();
    settings_run++;

    // step below 0.125 hits the eight-word cap; zero channel count acts as two
    write_reg(REG_PHASE_STEP, 32'h0100_0000);
    write_reg(REG_CHANNEL_COUNT, '0);
    pending_frames.push_back(fill_frame(SAMPLE_MAX));
    pending_frames.push_back(fill_frame(SAMPLE_MIN));
    pending_frames.push_back(mixed_frame(1'b0));
    wait_idle();
    settings_run++;

    // unused register index, one channel, step of exactly 0.125
    write_reg(REG_UNUSED, '1);
    write_reg(REG_PHASE_STEP, 32'h0200_0000);
    write_reg(REG_CHANNEL_COUNT, 32'd1);
    pending_frames.push_back(fill_frame(SAMPLE_MIN));
    pending_frames.push_back(fill_frame(SAMPLE_MAX));
    wait_idle();
    settings_run++;

    // largest step: frames with no word; channel count saturates
    write_reg(REG_PHASE_STEP, '1);
    write_reg(REG_CHANNEL_COUNT, 32'd15);
    pending_frames.push_back(fill_frame(SAMPLE_MAX));
    pending_frames.push_back(fill_frame(SAMPLE_MIN));
    pending_frames.push_back(mixed_frame(1'b1));
    pending_frames.push_back(fill_frame('0));
    wait_idle();
    settings_run++;

    // random settings, each followed by a run of random frames
    last = '0;
    for (int s = 0; s < RANDOM_SETTINGS; s++) begin
      case ($urandom_range(0, 9))
        0:       step = STEP_RESET;
        1:       step = $urandom();
        2:       step = $urandom_range(0, 32'h01FF_FFFF);
        3:       step = $urandom_range(32'h4000_0000, 32'hFFFF_FFFF);
        default: step = $urandom_range(32'h0200_0000, 32'h3000_0000);
      endcase
      chans = $urandom();
      if ($urandom_range(0, 3) != 0)
        chans[CH_BITS-1:0] = CH_BITS'($urandom_range(1, MAX_CHANNELS));
      first = $urandom_range(0, 2);
      for (int j = 0; j < 3; j++) begin
        case ((first + j) % 3)
          0: write_reg(REG_PHASE_STEP, step);
          1: write_reg(REG_CHANNEL_COUNT, chans);
          default: write_reg(REG_BYPASS,
                             {31'($urandom_range(0, 32'h7FFF_FFFF)),
                              ($urandom_range(0, 4) == 0)});
        endcase
      end
      for (int i = 0; i < FRAMES_PER_SETTING; i++) begin
        last = random_frame(last);
        pending_frames.push_back(last);
      end
      wait_idle();
      settings_run++;
    end

    $display("Sent %0d frames and checked %0d output words over %0d register settings",
             frames_in, words_seen, settings_run);
    $display("Covered bypass, capped and empty runs, channel count limits; %0d errors",
             errors);
    if (errors == 0) begin
      $display("PASS linear_interp_resampler");
    end else begin
      $display("FAIL linear_interp_resampler");
    end
    $finish;
  end

endmodule
`default_nettype wire
